[src/cdstr_pkg.sv]
package cdstr_pkg;

  // Fixed field widths of the pixel stream, the configuration registers and the internal sums and offsets.
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int FRAMES_W   = 8;
  localparam int SUM_W      = 26;
  localparam int TOT_W      = 37;
  localparam int OFS_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_FRAMES   = 2'd2;

  // Status that the back end reports to the front end.
  typedef struct packed {
    logic clear_done;
  } cdstr_status_t;

endpackage

[src/cdstr_ram.sv]
module cdstr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/cdstr_fifo.sv]
module cdstr_fifo #(
  parameter int WIDTH = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[src/cdstr_front.sv]
module cdstr_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [cdstr_pkg::PIX_W-1:0]           pixel,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       height,
  input  logic [cdstr_pkg::FRAMES_W-1:0]        frames,
  input  cdstr_pkg::cdstr_status_t              status,
  input  logic                                  fifo_full,
  output logic                                  push,
  output logic [$clog2(MAX_WIDTH)+cdstr_pkg::PIX_W+2:0] entry
);

  import cdstr_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [FRAMES_W-1:0] seen_r, seen_nxt;
  logic                ready_r, ready_nxt;
  logic                last_col, last_row, fend, fix;
  logic [FRAMES_W-1:0] seen_inc;

  assign in_tready = !fifo_full && status.clear_done;
  assign push      = in_tvalid && in_tready;

  // Classify the pixel: position flags and whether it closes calibration.
  always_comb begin
    last_col = ((WW+1)'(col_r) + (WW+1)'(1)) >= (WW+1)'(width);
    last_row = ((HW+1)'(row_r) + (HW+1)'(1)) >= (HW+1)'(height);
    fend     = last_col && last_row;
    seen_inc = seen_r + FRAMES_W'(1);
    fix      = !ready_r && fend && (seen_inc >= frames);
    entry    = {fix, fend, ready_r, col_r, pixel};
  end

  // Raster position and calibration progress.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    seen_nxt  = seen_r;
    ready_nxt = ready_r;
    if (push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (!ready_r && fend) begin
        seen_nxt = seen_inc;
      end
      if (fix) begin
        ready_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      seen_r  <= '0;
      ready_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      seen_r  <= seen_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

[src/cdstr_back.sv]
module cdstr_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$clog2(MAX_WIDTH)+cdstr_pkg::PIX_W+2:0] entry,
  input  logic                                  fifo_empty,
  output logic                                  pop,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        width,
  input  logic [$clog2(MAX_HEIGHT+1)+cdstr_pkg::FRAMES_W+$clog2(MAX_WIDTH+1)-1:0] den,
  output cdstr_pkg::cdstr_status_t              status,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [cdstr_pkg::PIX_W-1:0]           pixel_out,
  output logic                                  calibrated,
  output logic                                  frame_end
);

  import cdstr_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int DEN_W  = $clog2(MAX_HEIGHT + 1) + FRAMES_W + WW;
  localparam int PROD_W = SUM_W + WW;
  localparam int NUM_W  = ((PROD_W > TOT_W) ? PROD_W : TOT_W) + 1;
  localparam int CMP_W  = NUM_W + DEN_W;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_EXEC  = 8'b00000100,
    S_FRD   = 8'b00001000,
    S_FMUL  = 8'b00010000,
    S_FNUM  = 8'b00100000,
    S_FDIV  = 8'b01000000,
    S_FRND  = 8'b10000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [COL_W-1:0]           cnt_r, cnt_nxt;
  logic [PIX_W-1:0]           px_r;
  logic [COL_W-1:0]           icol_r;
  logic                       cal_r, fend_r, fix_r;
  logic [TOT_W-1:0]           total_r, total_nxt;
  logic [PROD_W-1:0]          prod_r;
  logic                       neg_r, sat_r;
  logic [CMP_W-1:0]           rem_r, rem_nxt;
  logic [PIX_W-1:0]           q_r, q_nxt;
  logic [2:0]                 k_r, k_nxt;
  logic                       ov_r, ov_nxt;
  logic [PIX_W-1:0]           po_r;
  logic                       pc_r, pf_r;

  logic                       go, load;
  logic [COL_W-1:0]           raddr;
  logic                       sum_we;
  logic [COL_W-1:0]           sum_waddr;
  logic [SUM_W-1:0]           sum_wdata, sum_rdata;
  logic                       ofs_we;
  logic [OFS_W-1:0]           ofs_wdata, ofs_rdata;
  logic [9:0]                 diff;
  logic [PIX_W-1:0]           corr;
  logic [NUM_W-1:0]           prod_e, tot_e, mag_a;
  logic [CMP_W-1:0]           dsh;
  logic [DEN_W:0]             twice_r;
  logic                       round_up;
  logic [8:0]                 qmag;
  logic [8:0]                 qneg;
  logic                       last_cnt;

  assign status.clear_done = !(state_r == S_CLEAR);
  assign go       = !ov_r || out_tready;
  assign load     = (state_r == S_EXEC) && go;
  assign pop      = (state_r == S_IDLE) && !fifo_empty;
  assign last_cnt = (cnt_r == COL_W'(MAX_WIDTH - 1));

  // Read address follows the item about to run, the held item or the sweep.
  always_comb begin
    priority if (state_r == S_IDLE) begin
      raddr = entry[PIX_W +: COL_W];
    end else if (state_r == S_EXEC) begin
      raddr = icol_r;
    end else begin
      raddr = cnt_r;
    end
  end

  cdstr_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_sums (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (raddr),
    .rdata (sum_rdata)
  );

  cdstr_ram #(.WIDTH(OFS_W), .DEPTH(MAX_WIDTH)) u_offsets (
    .clk   (clk),
    .we    (ofs_we),
    .waddr (cnt_r),
    .wdata (ofs_wdata),
    .raddr (raddr),
    .rdata (ofs_rdata)
  );

  // Column sum write: zero during the clearing pass, accumulate while calibrating.
  always_comb begin
    sum_we    = (state_r == S_CLEAR) || (load && !cal_r);
    sum_waddr = (state_r == S_CLEAR) ? cnt_r : icol_r;
    sum_wdata = (state_r == S_CLEAR) ? '0 : sum_rdata + SUM_W'(px_r);
    total_nxt = (load && !cal_r) ? total_r + TOT_W'(px_r) : total_r;
  end

  // Corrected pixel: input minus offset, clamped to 0..255.
  always_comb begin
    diff = {2'b00, px_r} - {{2{ofs_rdata[OFS_W-1]}}, ofs_rdata};
    priority if (diff[9]) begin
      corr = '0;
    end else if (diff[8]) begin
      corr = '1;
    end else begin
      corr = diff[7:0];
    end
  end

  // Offset arithmetic: magnitude of the numerator, shifted divisor, rounding.
  always_comb begin
    prod_e   = NUM_W'(prod_r);
    tot_e    = NUM_W'(total_r);
    mag_a    = (prod_e < tot_e) ? tot_e - prod_e : prod_e - tot_e;
    dsh      = CMP_W'(den) << k_r;
    twice_r  = {rem_r[DEN_W-1:0], 1'b0};
    round_up = (twice_r > {1'b0, den}) || ((twice_r == {1'b0, den}) && q_r[0]);
    qmag     = sat_r ? 9'd256 : {1'b0, q_r} + {8'd0, round_up};
    qneg     = 9'd0 - qmag;
    priority if (neg_r) begin
      ofs_wdata = (qmag > 9'd128) ? 8'h80 : qneg[7:0];
    end else begin
      ofs_wdata = (qmag > 9'd127) ? 8'h7F : qmag[7:0];
    end
    ofs_we = (state_r == S_FRND);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    ov_nxt    = load ? 1'b1 : (out_tready ? 1'b0 : ov_r);
    unique case (state_r)
      S_CLEAR: begin
        cnt_nxt = last_cnt ? '0 : cnt_r + COL_W'(1);
        if (last_cnt) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_nxt = fix_r ? S_FRD : S_IDLE;
          cnt_nxt   = '0;
        end
      end
      S_FRD: begin
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        state_nxt = S_FNUM;
      end
      S_FNUM: begin
        rem_nxt   = CMP_W'(mag_a);
        q_nxt     = '0;
        k_nxt     = 3'd7;
        state_nxt = (CMP_W'(mag_a) >= (CMP_W'(den) << 8)) ? S_FRND : S_FDIV;
      end
      S_FDIV: begin
        if (rem_r >= dsh) begin
          rem_nxt  = rem_r - dsh;
          q_nxt    = q_r | (PIX_W'(1) << k_r);
        end
        k_nxt = k_r - 3'd1;
        if (k_r == 3'd0) begin
          state_nxt = S_FRND;
        end
      end
      S_FRND: begin
        cnt_nxt   = cnt_r + COL_W'(1);
        state_nxt = last_cnt ? S_IDLE : S_FRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      px_r   <= entry[PIX_W-1:0];
      icol_r <= entry[PIX_W +: COL_W];
      cal_r  <= entry[PIX_W + COL_W];
      fend_r <= entry[PIX_W + COL_W + 1];
      fix_r  <= entry[PIX_W + COL_W + 2];
    end
    if (state_r == S_FMUL) begin
      prod_r <= PROD_W'(sum_rdata * width);
    end
    if (state_r == S_FNUM) begin
      neg_r <= (prod_e < tot_e);
      sat_r <= (CMP_W'(mag_a) >= (CMP_W'(den) << 8));
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
    if (load) begin
      po_r <= cal_r ? corr : px_r;
      pc_r <= cal_r;
      pf_r <= fend_r;
    end
  end

  assign out_tvalid = ov_r;
  assign pixel_out  = po_r;
  assign calibrated = pc_r;
  assign frame_end  = pf_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == S_IDLE))
    else $error("item taken from queue while back end busy");

  a_fix_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (load && fix_r) |=> (state_r == S_FRD) && (cnt_r == '0))
    else $error("offset sweep did not start after last calibration pixel");

  a_no_acc_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (load && cal_r) |=> $stable(total_r))
    else $error("grand total changed after calibration");

endmodule

[src/column_destripe_calibrate.sv]
// Column fixed-pattern noise correction for an 8-bit raster pixel stream.
// Pixels arrive on the in_ channel (tdata = pixel) and leave on the out_
// channel, one result per pixel: tdata = pixel_out, tuser = calibrated,
// tlast = frame_end. Frame size and the number of calibration frames are
// written on the cfg_ channel (index 0 width, 1 height, 2 frames); the
// user must write them only while idle, which the block does not enforce.
// During calibration pixels pass through unchanged and exact column sums are
// gathered; after the last calibration frame every column offset is computed
// once and later pixels are corrected by subtracting it, clamped to 0..255.
// The back end handles one pixel at a time, set by the read-modify-write of
// the column sum memory: read while idle, written back in the execute state.
// The one-time offset sweep takes each of the MAX_WIDTH columns through
// memory read, multiply, subtract, eight divide steps and round, skipping
// the divide steps when the offset saturates; during the sweep the input
// stalls. After reset the column sum memory is cleared and no pixel is
// accepted. A stalled receiver holds the output register; the input side
// keeps filling a two-entry queue and then deasserts in_tready.
module column_destripe_calibrate #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [cdstr_pkg::PIX_W-1:0]          in_tdata,   // [7:0] pixel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [cdstr_pkg::PIX_W-1:0]          out_tdata,  // [7:0] pixel_out
  output logic                                 out_tuser,  // [0] calibrated
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cdstr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cdstr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import cdstr_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEN_W = HW + FRAMES_W + WW;
  localparam int ENT_W = COL_W + PIX_W + 3;

  logic [SIZE_W-1:0]     fw_r, fh_r;
  logic [FRAMES_W-1:0]   fc_r;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic [FRAMES_W-1:0]   f_eff;
  logic [HW+FRAMES_W-1:0] hf_r;
  logic [DEN_W-1:0]      den_r;
  cdstr_status_t         status;
  logic                  push, pop, full, empty;
  logic [ENT_W-1:0]      wentry, rentry;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= SIZE_W'(640);
      fh_r <= SIZE_W'(512);
      fc_r <= FRAMES_W'(30);
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        fw_r <= cfg_data;
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        fh_r <= cfg_data;
      end
      if (cfg_index == REG_CAL_FRAMES) begin
        fc_r <= cfg_data[FRAMES_W-1:0];
      end
    end
  end

  // Sizes in range: zero counts as one, anything larger as the maximum.
  always_comb begin
    priority if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    priority if (fh_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh_r);
    end
    f_eff = (fc_r == '0) ? FRAMES_W'(1) : fc_r;
  end

  // Divisor height * frames * width, two registered multiplies.
  always_ff @(posedge clk) begin
    hf_r  <= h_eff * f_eff;
    den_r <= DEN_W'(hf_r * w_eff);
  end

  cdstr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .pixel     (in_tdata),
    .width     (w_eff),
    .height    (h_eff),
    .frames    (f_eff),
    .status    (status),
    .fifo_full (full),
    .push      (push),
    .entry     (wentry)
  );

  cdstr_fifo #(.WIDTH(ENT_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wentry),
    .pop   (pop),
    .rdata (rentry),
    .full  (full),
    .empty (empty)
  );

  cdstr_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .entry      (rentry),
    .fifo_empty (empty),
    .pop        (pop),
    .width      (w_eff),
    .den        (den_r),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .pixel_out  (out_tdata),
    .calibrated (out_tuser),
    .frame_end  (out_tlast)
  );

endmodule

[tb/column_destripe_calibrate_test.sv]
`timescale 1ns / 100ps

module column_destripe_calibrate_test;
  import cdstr_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 1024;
  localparam int CYCLE_CAP  = 400000;
  localparam int SETTLE     = 8;
  // Index past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [PIX_W-1:0] pixel_out;
    logic             calibrated;
    logic             frame_end;
  } corrected_pixel_t;

  // Tracks the raster position and calibration state and keeps the
  // corrected pixels that the block still owes.
  class destripe_scoreboard;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [SUM_W-1:0]    col_sum[MAX_W];
    logic [TOT_W-1:0]    pixel_total;
    logic signed [OFS_W-1:0] col_offset[MAX_W];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [7:0]          frames_done;
    bit                  offsets_fixed;
    corrected_pixel_t    pending_pixels[$];
    int                  mismatches;

    function new();
      width_reg = 640;
      height_reg = 512;
      frames_reg = 30;
      pixel_total = '0;
      col_pos = 0;
      row_pos = 0;
      frames_done = '0;
      offsets_fixed = 0;
      mismatches = 0;
      foreach (col_sum[c]) begin
        col_sum[c] = '0;
        col_offset[c] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH: width_reg = val;
        REG_FRAME_HEIGHT: height_reg = val;
        REG_CAL_FRAMES: frames_reg = val[FRAMES_W-1:0];
        default: ;
      endcase
    endfunction

    // Rounded (half to even) quotient, saturated to the signed offset range.
    function logic signed [OFS_W-1:0] rounded_offset(longint num, longint den);
      longint mag;
      longint q;
      longint r;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      r = mag % den;
      if (2 * r > den || (2 * r == den && q[0])) q++;
      if (num < 0) begin
        if (q > 128) q = 128;
        return OFS_W'(-q);
      end
      if (q > 127) q = 127;
      return OFS_W'(q);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned w, h, f, col;
      bit last_col, last_row;
      int v;
      longint den;
      corrected_pixel_t exp_px;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > MAX_H) ? MAX_H : height_reg;
      f = (frames_reg == 0) ? 1 : frames_reg;
      col = col_pos % MAX_W;
      last_col = col_pos + 1 >= w;
      last_row = row_pos + 1 >= h;
      exp_px.frame_end = last_col && last_row;
      exp_px.calibrated = offsets_fixed;
      if (offsets_fixed) begin
        v = int'(px) - int'(col_offset[col]);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        exp_px.pixel_out = PIX_W'(v);
      end else begin
        exp_px.pixel_out = px;
        col_sum[col] = col_sum[col] + px;
        pixel_total = pixel_total + px;
        if (exp_px.frame_end) begin
          frames_done = 8'(frames_done + 1);
          if (frames_done >= f) begin
            // Last calibration pixel: every column offset is fixed here.
            den = longint'(h) * f * w;
            foreach (col_offset[c])
              col_offset[c] = rounded_offset(longint'(col_sum[c]) * w -
                                             longint'(pixel_total), den);
            offsets_fixed = 1;
          end
        end
      end
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
      pending_pixels.push_back(exp_px);
    endfunction

    function void check_pixel(logic [PIX_W-1:0] pix, logic cal, logic fend);
      corrected_pixel_t exp_px;
      if (pending_pixels.size() == 0) begin
        $error("unexpected transfer: pixel_out %0d", pix);
        mismatches++;
        return;
      end
      exp_px = pending_pixels.pop_front();
      if (pix !== exp_px.pixel_out) begin
        $error("pixel_out: expected %0d, actual %0d", exp_px.pixel_out, pix);
        mismatches++;
      end
      if (cal !== exp_px.calibrated) begin
        $error("calibrated: expected %0d, actual %0d", exp_px.calibrated, cal);
        mismatches++;
      end
      if (fend !== exp_px.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", exp_px.frame_end, fend);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  destripe_scoreboard sb = new();
  bit  quiet_tail = 0;
  int  cycle_count = 0;
  int  out_count = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  column_destripe_calibrate i_dut (.*);

  always #2 clk = ~clk;

  // Cycle limit against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: checks each output transfer, stalls in random bursts and
  // holds off once for a long stretch so that the input side backs up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_pixel(out_tdata, out_tuser, out_tlast);
        out_count <= out_count + 1;
        if (out_count == 300) hold_left <= 200;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] px);
    int gap;
    in_tvalid <= 1;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(px);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register writes happen only once the block has drained.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Column-biased pixels so that the offsets differ per column; the two
  // first columns sit at the rails to drive the offsets into saturation.
  task automatic send_striped(int count);
    int unsigned col;
    int v;
    for (int i = 0; i < count; i++) begin
      col = sb.col_pos;
      if (col == 0) v = 255;
      else if (col == 1) v = 0;
      else v = 64 + col * 23 % 128 + $urandom_range(0, 40);
      send_pixel(PIX_W'(v));
    end
  endtask

  initial begin
    logic [PIX_W-1:0] directed[] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                     8'h55, 8'hAA, 8'h0F, 8'hF0};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Widest frame, height of zero taken as one, most calibration frames.
    write_cfg(REG_FRAME_WIDTH, 11'd2047);
    write_cfg(REG_FRAME_HEIGHT, 11'd0);
    write_cfg(REG_CAL_FRAMES, 11'd255);
    write_cfg(REG_UNUSED, 11'd3);
    foreach (directed[i]) send_pixel(directed[i]);
    send_striped(10);

    // Shrink the frame mid-row: the position wraps at once.
    write_cfg(REG_FRAME_WIDTH, 11'd5);
    write_cfg(REG_FRAME_HEIGHT, 11'd3);
    write_cfg(REG_CAL_FRAMES, 11'd3);
    send_striped(40);

    // The first pixel here closes calibration; a width of zero acts as one column.
    write_cfg(REG_FRAME_WIDTH, 11'd0);
    write_cfg(REG_CAL_FRAMES, 11'd0);
    foreach (directed[i]) send_pixel(directed[i]);

    write_cfg(REG_FRAME_WIDTH, 11'd7);
    write_cfg(REG_FRAME_HEIGHT, 11'd4);
    write_cfg(REG_CAL_FRAMES, 11'd2047);
    for (int i = 0; i < 500; i++) send_pixel(PIX_W'($urandom_range(0, 255)));

    write_cfg(REG_FRAME_WIDTH, 11'd1024);
    write_cfg(REG_FRAME_HEIGHT, 11'd1024);
    write_cfg(REG_CAL_FRAMES, 11'd1);
    for (int i = 0; i < 300; i++) send_pixel(PIX_W'($urandom_range(0, 255)));

    write_cfg(REG_FRAME_WIDTH, 11'd3);
    write_cfg(REG_FRAME_HEIGHT, 11'd2047);
    for (int i = 0; i < 60; i++) send_pixel(PIX_W'($urandom_range(0, 255)));

    // Closing stretch at full rate on both sides.
    write_cfg(REG_FRAME_HEIGHT, 11'd2);
    quiet_tail = 1;
    for (int i = 0; i < 150; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
    in_tvalid <= 0;

    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
src/cdstr_pkg.sv
src/cdstr_ram.sv
src/cdstr_fifo.sv
src/cdstr_front.sv
src/cdstr_back.sv
src/column_destripe_calibrate.sv
tb/column_destripe_calibrate_test.sv
